// File: rtl/core/hpq_pkg.sv
// shared types and codes for the binary min-heap queue
`timescale 1ns / 1ps

package hpq_pkg;

  // operation codes on op_i
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status from the sequencer when a transaction completes
  typedef struct packed {
    logic fin;
    logic rejected;
  } hpq_stat_t;

endpackage

// File: rtl/core/hpq_ram.sv
// heap key store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module hpq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hpq_seq.sv
// sift sequencer with the shared key comparator
`timescale 1ns / 1ps

module hpq_seq import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32,
  localparam int unsigned AW      = $clog2(CAPACITY),
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                op_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                busy_o,
  output logic [CW-1:0]       count_o,
  output logic [KEY_BITS-1:0] root_o,
  output hpq_stat_t           stat_o,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output logic [KEY_BITS-1:0] ram_wdata_o,
  output logic [AW-1:0]       ram_raddr_o,
  input  logic [KEY_BITS-1:0] ram_rdata_i
);

  localparam int unsigned IW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_L,
    S_DN_R,
    S_DN_SEL
  } state_e;

  // the compare after the candidate child is chosen has its own phase flag
  typedef enum logic {
    C_OFF,
    C_ON
  } cmp_ph_e;

  state_e              state_q, state_d;
  cmp_ph_e             cph_q, cph_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       cidx_q, cidx_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] cand_q, cand_d;
  logic [KEY_BITS-1:0] root_q, root_d;
  logic [CW-1:0]       count_q, count_d;

  logic [AW-1:0]       parent;
  logic [IW-1:0]       lft;
  logic [IW-1:0]       rgt;
  logic [IW-1:0]       cnt_ext;

  // shared comparator
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                cmp_lt;

  assign parent  = (pos_q - AW'(1)) >> 1;
  assign lft     = {1'b0, pos_q, 1'b1};
  assign rgt     = lft + IW'(1);
  assign cnt_ext = IW'(count_q);
  assign cmp_lt  = cmp_a < cmp_b;

  always_comb begin
    state_d     = state_q;
    cph_d       = C_OFF;
    pos_d       = pos_q;
    cidx_d      = cidx_q;
    key_d       = key_q;
    cand_d      = cand_q;
    count_d     = count_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = key_q;
    ram_raddr_o = '0;
    cmp_a       = key_q;
    cmp_b       = ram_rdata_i;
    stat_o      = '0;

    if (cph_q == C_ON) begin
      // candidate child against the key being sifted down
      cmp_a = cand_q;
      cmp_b = key_q;
      if (cmp_lt) begin
        ram_we_o    = 1'b1;
        ram_wdata_o = cand_q;
        pos_d       = cidx_q;
        state_d     = S_DN_L;
      end else begin
        ram_we_o   = 1'b1;
        stat_o.fin = 1'b1;
        state_d    = S_IDLE;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (op_i == OP_PUSH) begin
              if (count_q == CW'(CAPACITY)) begin
                stat_o.fin      = 1'b1;
                stat_o.rejected = 1'b1;
              end else begin
                key_d   = key_i;
                pos_d   = count_q[AW-1:0];
                count_d = count_q + CW'(1);
                state_d = S_UP_RD;
              end
            end else begin
              if (count_q == '0) begin
                stat_o.fin = 1'b1;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  stat_o.fin = 1'b1;
                end else begin
                  state_d = S_DN_LAST;
                end
              end
            end
          end
        end
        S_UP_RD: begin
          if (pos_q == '0) begin
            ram_we_o   = 1'b1;
            stat_o.fin = 1'b1;
            state_d    = S_IDLE;
          end else begin
            ram_raddr_o = parent;
            state_d     = S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          // parent strictly greater moves down into the hole
          if (cmp_lt) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = ram_rdata_i;
            pos_d       = parent;
            state_d     = S_UP_RD;
          end else begin
            ram_we_o   = 1'b1;
            stat_o.fin = 1'b1;
            state_d    = S_IDLE;
          end
        end
        S_DN_LAST: begin
          ram_raddr_o = count_q[AW-1:0];
          state_d     = S_DN_LOAD;
        end
        S_DN_LOAD: begin
          key_d   = ram_rdata_i;
          pos_d   = '0;
          state_d = S_DN_L;
        end
        S_DN_L: begin
          if (lft >= cnt_ext) begin
            ram_we_o   = 1'b1;
            stat_o.fin = 1'b1;
            state_d    = S_IDLE;
          end else begin
            ram_raddr_o = lft[AW-1:0];
            state_d     = S_DN_R;
          end
        end
        S_DN_R: begin
          cand_d = ram_rdata_i;
          cidx_d = lft[AW-1:0];
          if (rgt < cnt_ext) begin
            ram_raddr_o = rgt[AW-1:0];
            state_d     = S_DN_SEL;
          end else begin
            cph_d = C_ON;
          end
        end
        S_DN_SEL: begin
          // right child wins only when strictly smaller
          cmp_a = ram_rdata_i;
          cmp_b = cand_q;
          if (cmp_lt) begin
            cand_d = ram_rdata_i;
            cidx_d = rgt[AW-1:0];
          end
          cph_d = C_ON;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end

    root_d = root_q;
    if (ram_we_o && (ram_waddr_o == '0)) begin
      root_d = ram_wdata_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cph_q   <= C_OFF;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      cph_q   <= cph_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cidx_q <= cidx_d;
    key_q  <= key_d;
    cand_q <= cand_d;
    root_q <= root_d;
  end

  assign busy_o  = (state_q != S_IDLE) || (cph_q == C_ON);
  assign count_o = count_q;
  assign root_o  = root_q;

endmodule

// File: rtl/core/binary_min_heap_queue.sv
// top level of the binary min-heap priority queue
`timescale 1ns / 1ps

// usage
//  - a transaction is taken at a rising edge with start_i high and busy_o low:
//    op_i selects push of key_i or pop of the current minimum
//  - busy_o stays high while the sift runs; no new transaction is taken then
//  - each transaction gives one result, shown for exactly one cycle with
//    done_o high: min_key_o, min_valid_o, entry_count_o and rejected_o
//    describe the heap after the operation
//  - steps: a push on a full heap or a pop on at most one key needs no sift;
//    a push runs S_UP_RD and S_UP_CMP per level climbed; a pop fetches the
//    last key in S_DN_LAST and S_DN_LOAD, then per level descended runs
//    S_DN_L, S_DN_R, S_DN_SEL (with a right child) and the compare phase
//  - the single read port of the key store sets the pace: every level needs
//    a read, a compare in the shared comparator and a write
//  - the next transaction may start in the cycle the result is shown
//  - the receiver cannot stall; a result not taken in its cycle is gone
//  - reset empties the heap; the key store itself is not cleared, as only
//    entries that hold a pushed key are ever used
module binary_min_heap_queue import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32,
  localparam int unsigned AW      = $clog2(CAPACITY),
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic          op_i,
  input  logic [31:0]   key_i,
  output logic          done_o,
  output logic [31:0]   min_key_o,
  output logic          min_valid_o,
  output logic [CW-1:0] entry_count_o,
  output logic          rejected_o
);

  logic [KEY_BITS-1:0] key_ext;
  logic [KEY_BITS-1:0] root;
  logic [CW-1:0]       count;
  hpq_stat_t           stat;

  // key store port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  // result strobe and flag
  logic done_q, rejected_q;

  // stored keys keep their low KEY_BITS bits
  assign key_ext = KEY_BITS'(key_i);

  hpq_seq #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .key_i       (key_ext),
    .busy_o      (busy_o),
    .count_o     (count),
    .root_o      (root),
    .stat_o      (stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  hpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result strobe follows the cycle in which the sift completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      rejected_q <= 1'b0;
    end else begin
      done_q     <= stat.fin;
      rejected_q <= stat.rejected;
    end
  end

  // count and root are registers already updated when the strobe shows
  assign done_o        = done_q;
  assign rejected_o    = rejected_q;
  assign min_valid_o   = (count != '0);
  assign min_key_o     = (count != '0) ? 32'(root) : '0;
  assign entry_count_o = count;

endmodule
